// File: rtl/core/playfair_digraph_encryptor_assert.svh
// Assertion macros used by the Playfair encryptor checker.
`ifndef PLAYFAIR_DIGRAPH_ENCRYPTOR_ASSERT_SVH
`define PLAYFAIR_DIGRAPH_ENCRYPTOR_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PFE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define PFE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/pfe_pkg.sv
// Types, constants and helper functions of the Playfair encryptor.
package pfe_pkg;

    localparam int SQ_DIM    = 5;
    localparam int SQ_CELLS  = SQ_DIM * SQ_DIM;
    localparam int N_LETTERS = 26;

    localparam logic [4:0] LETTER_I = 5'd8;
    localparam logic [4:0] LETTER_J = 5'd9;
    localparam logic [4:0] LETTER_X = 5'd23;
    localparam logic [4:0] LETTER_LAST = 5'(N_LETTERS - 1);

    localparam logic [7:0] ASCII_LOWER_A = 8'd97;
    localparam logic [7:0] ASCII_LOWER_Z = 8'd122;
    localparam logic [7:0] ASCII_UPPER_A = 8'd65;
    localparam logic [7:0] ASCII_UPPER_Z = 8'd90;

    typedef enum logic [2:0] {
        OP_CLEAR  = 3'd0,
        OP_KEY    = 3'd1,
        OP_FINISH = 3'd2,
        OP_TEXT   = 3'd3,
        OP_END    = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FILL,
        S_POS,
        S_SQ
    } state_t;

    typedef struct packed {
        logic       valid;
        logic [4:0] idx;
    } letter_t;

    typedef struct packed {
        logic [2:0] row;
        logic [2:0] col;
    } rc_t;

    // Folds case and maps j onto i; non-letters come back not valid.
    function automatic letter_t letter_of(input logic [7:0] c);
        letter_t r;
        r.valid = 1'b0;
        r.idx   = '0;
        if (c >= ASCII_LOWER_A && c <= ASCII_LOWER_Z) begin
            r.valid = 1'b1;
            r.idx   = 5'(c - ASCII_LOWER_A);
        end else if (c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z) begin
            r.valid = 1'b1;
            r.idx   = 5'(c - ASCII_UPPER_A);
        end
        if (r.idx == LETTER_J) begin
            r.idx = LETTER_I;
        end
        return r;
    endfunction

    // Splits a square place into row and column.
    function automatic rc_t place_rc(input logic [4:0] p);
        rc_t        r;
        logic [4:0] base;
        if (p >= 5'd20) begin
            r.row = 3'd4;
        end else if (p >= 5'd15) begin
            r.row = 3'd3;
        end else if (p >= 5'd10) begin
            r.row = 3'd2;
        end else if (p >= 5'd5) begin
            r.row = 3'd1;
        end else begin
            r.row = 3'd0;
        end
        base  = {r.row, 2'b00} + {2'b00, r.row};
        r.col = 3'(p - base);
        return r;
    endfunction

    function automatic logic [4:0] sq_addr(input logic [2:0] row, input logic [2:0] col);
        return {row, 2'b00} + {2'b00, row} + {2'b00, col};
    endfunction

    function automatic logic [2:0] wrap_inc(input logic [2:0] v);
        return (v == 3'(SQ_DIM - 1)) ? 3'd0 : v + 3'd1;
    endfunction

    function automatic logic [6:0] to_ascii(input logic [4:0] l);
        return 7'(ASCII_LOWER_A) + {2'b00, l};
    endfunction

endpackage

// File: rtl/core/playfair_digraph_encryptor.sv
// Playfair encryptor top level: key square build, text pairing and encryption.
// A text or end request that completes a pair goes through the place read and square read
// states before its first letter is shown, and holds the block longer while the output cannot take it.
// Clear, key and all other requests leave the block idle; a finish request holds it for the
// walk over the alphabet, which places each letter not yet used.
// Reset clears the used map, fill count, pending letter and output buffer; the
// square memories are not cleared and hold whatever they had until written.
module playfair_digraph_encryptor (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  logic [2:0] op,
    input  logic [7:0] in_char,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    output logic [6:0] out_char,
    output logic       pair_last,
    output logic       message_end
);

    // The key square lives in two small synchronous memories: the square itself,
    // indexed by place, and its inverse, indexed by letter. Both have registered read data.
    logic [4:0] ks_mem [pfe_pkg::SQ_CELLS];
    logic [4:0] lp_mem [pfe_pkg::N_LETTERS];

    pfe_pkg::state_t state_reg, state_next;

    logic [pfe_pkg::N_LETTERS-1:0] used_reg, used_next;
    logic [4:0] fill_count_reg, fill_count_next;
    logic [4:0] fill_idx_reg, fill_idx_next;

    // Text pairing state: the held first letter of a pair, its adjacency flag and the end flag.
    logic [4:0] pend_letter_reg, pend_letter_next;
    logic       pend_valid_reg, pend_valid_next;
    logic       pend_adj_reg, pend_adj_next;
    logic       at_end_reg, at_end_next;

    // Memory read data and held square read addresses.
    logic [4:0] lp_a_reg, lp_b_reg;
    logic [4:0] ks_a_reg, ks_b_reg;
    logic [4:0] ka_reg, kb_reg;

    // Two-entry output buffer; a count of two shows the first letter.
    logic [4:0] o_char0_reg, o_char1_reg;
    logic       o_end_reg;
    logic [1:0] o_cnt_reg, o_cnt_next;

    logic            req_accept;
    logic            rsp_accept;
    pfe_pkg::letter_t lt;
    pfe_pkg::op_t    op_code;

    logic       pair_go;
    logic [4:0] pair_a, pair_b;

    logic       place_req, place_en;
    logic [4:0] place_src;

    pfe_pkg::rc_t rc_a, rc_b;
    logic [4:0]   ka_calc, kb_calc, ka_addr, kb_addr;
    logic         out_free, out_load;

    assign req_ready  = (state_reg == pfe_pkg::S_IDLE);
    assign req_accept = req_valid && req_ready;
    assign rsp_valid  = (o_cnt_reg != 2'd0);
    assign rsp_accept = rsp_valid && rsp_ready;
    assign lt         = pfe_pkg::letter_of(in_char);
    assign op_code    = pfe_pkg::op_t'(op);

    assign out_char    = pfe_pkg::to_ascii((o_cnt_reg == 2'd2) ? o_char0_reg : o_char1_reg);
    assign pair_last   = (o_cnt_reg == 2'd1);
    assign message_end = (o_cnt_reg == 2'd1) && o_end_reg;

    // Pairing of text letters. A repeated letter that directly follows the held
    // first letter closes the pair with an x and stays held as the next first letter.
    always_comb
    begin
        pair_go          = 1'b0;
        pair_a           = pend_letter_reg;
        pair_b           = pfe_pkg::LETTER_X;
        pend_letter_next = pend_letter_reg;
        pend_valid_next  = pend_valid_reg;
        pend_adj_next    = pend_adj_reg;
        at_end_next      = at_end_reg;
        if (req_accept) begin
            case (op_code)
                pfe_pkg::OP_TEXT:
                begin
                    if (!lt.valid) begin
                        pend_adj_next = 1'b0;
                    end else if (!pend_valid_reg) begin
                        pend_letter_next = lt.idx;
                        pend_valid_next  = 1'b1;
                        pend_adj_next    = 1'b1;
                    end else if (pend_adj_reg && lt.idx == pend_letter_reg) begin
                        pair_go     = 1'b1;
                        at_end_next = 1'b0;
                    end else begin
                        pair_go         = 1'b1;
                        pair_b          = lt.idx;
                        at_end_next     = 1'b0;
                        pend_valid_next = 1'b0;
                        pend_adj_next   = 1'b0;
                    end
                end
                pfe_pkg::OP_END:
                begin
                    pend_adj_next = 1'b0;
                    if (pend_valid_reg) begin
                        pair_go         = 1'b1;
                        at_end_next     = 1'b1;
                        pend_valid_next = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Letter placement, shared by key requests and the finish walk.
    always_comb
    begin
        place_src = (state_reg == pfe_pkg::S_FILL) ? fill_idx_reg : lt.idx;
        place_req = ((state_reg == pfe_pkg::S_FILL) && fill_idx_reg != pfe_pkg::LETTER_J)
                 || (req_accept && op_code == pfe_pkg::OP_KEY && lt.valid);
        place_en  = place_req && !used_reg[place_src]
                 && (fill_count_reg < 5'(pfe_pkg::SQ_CELLS));

        used_next       = used_reg;
        fill_count_next = fill_count_reg;
        if (req_accept && op_code == pfe_pkg::OP_CLEAR) begin
            used_next       = '0;
            fill_count_next = '0;
        end else if (place_en) begin
            used_next[place_src] = 1'b1;
            fill_count_next      = fill_count_reg + 5'd1;
        end
    end

    // Cipher places from the two letter places: row rule, column rule or rectangle.
    always_comb
    begin
        rc_a = pfe_pkg::place_rc(lp_a_reg);
        rc_b = pfe_pkg::place_rc(lp_b_reg);
        if (rc_a.row == rc_b.row) begin
            ka_calc = pfe_pkg::sq_addr(rc_a.row, pfe_pkg::wrap_inc(rc_a.col));
            kb_calc = pfe_pkg::sq_addr(rc_b.row, pfe_pkg::wrap_inc(rc_b.col));
        end else if (rc_a.col == rc_b.col) begin
            ka_calc = pfe_pkg::sq_addr(pfe_pkg::wrap_inc(rc_a.row), rc_a.col);
            kb_calc = pfe_pkg::sq_addr(pfe_pkg::wrap_inc(rc_b.row), rc_b.col);
        end else begin
            ka_calc = pfe_pkg::sq_addr(rc_a.row, rc_b.col);
            kb_calc = pfe_pkg::sq_addr(rc_b.row, rc_a.col);
        end
        ka_addr = (state_reg == pfe_pkg::S_POS) ? ka_calc : ka_reg;
        kb_addr = (state_reg == pfe_pkg::S_POS) ? kb_calc : kb_reg;
    end

    // The pair waits in the square read state until the output buffer can take it.
    assign out_free = (o_cnt_reg == 2'd0) || (o_cnt_reg == 2'd1 && rsp_ready);
    assign out_load = (state_reg == pfe_pkg::S_SQ) && out_free;

    always_comb
    begin
        o_cnt_next = o_cnt_reg;
        if (out_load) begin
            o_cnt_next = 2'd2;
        end else if (rsp_accept) begin
            o_cnt_next = o_cnt_reg - 2'd1;
        end
    end

    // Sequencer: next state.
    always_comb
    begin
        state_next    = state_reg;
        fill_idx_next = fill_idx_reg;
        case (state_reg)
            pfe_pkg::S_IDLE:
            begin
                if (req_accept && op_code == pfe_pkg::OP_FINISH) begin
                    state_next    = pfe_pkg::S_FILL;
                    fill_idx_next = '0;
                end else if (pair_go) begin
                    state_next = pfe_pkg::S_POS;
                end
            end
            pfe_pkg::S_FILL:
            begin
                fill_idx_next = fill_idx_reg + 5'd1;
                if (fill_idx_reg == pfe_pkg::LETTER_LAST) begin
                    state_next = pfe_pkg::S_IDLE;
                end
            end
            pfe_pkg::S_POS:
            begin
                state_next = pfe_pkg::S_SQ;
            end
            pfe_pkg::S_SQ:
            begin
                if (out_free) begin
                    state_next = pfe_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pfe_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg       <= pfe_pkg::S_IDLE;
            used_reg        <= '0;
            fill_count_reg  <= '0;
            fill_idx_reg    <= '0;
            pend_letter_reg <= '0;
            pend_valid_reg  <= 1'b0;
            pend_adj_reg    <= 1'b0;
            at_end_reg      <= 1'b0;
            o_cnt_reg       <= '0;
        end else begin
            state_reg       <= state_next;
            used_reg        <= used_next;
            fill_count_reg  <= fill_count_next;
            fill_idx_reg    <= fill_idx_next;
            pend_letter_reg <= pend_letter_next;
            pend_valid_reg  <= pend_valid_next;
            pend_adj_reg    <= pend_adj_next;
            at_end_reg      <= at_end_next;
            o_cnt_reg       <= o_cnt_next;
        end
    end

    // Letter-to-place memory: written on placement, read at both pair letters.
    always_ff @(posedge clk)
    begin
        if (place_en) begin
            lp_mem[place_src] <= fill_count_reg;
        end
        lp_a_reg <= lp_mem[pair_a];
        lp_b_reg <= lp_mem[pair_b];
    end

    // Square memory: written on placement, read at both cipher places.
    always_ff @(posedge clk)
    begin
        if (place_en) begin
            ks_mem[fill_count_reg] <= place_src;
        end
        ks_a_reg <= ks_mem[ka_addr];
        ks_b_reg <= ks_mem[kb_addr];
        ka_reg   <= ka_addr;
        kb_reg   <= kb_addr;
    end

    always_ff @(posedge clk)
    begin
        if (out_load) begin
            o_char0_reg <= ks_a_reg;
            o_char1_reg <= ks_b_reg;
            o_end_reg   <= at_end_reg;
        end
    end

endmodule

// File: rtl/core/pfe_checker.sv
// Port-level checker for the Playfair encryptor, bound to the top level.
`include "playfair_digraph_encryptor_assert.svh"

module pfe_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic [2:0] op,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [6:0] out_char,
    input logic       pair_last,
    input logic       message_end
);

    logic rsp_stall;
    logic rsp_take;
    logic finish_take;

    assign rsp_stall   = rsp_valid && !rsp_ready;
    assign rsp_take    = rsp_valid && rsp_ready;
    assign finish_take = req_valid && req_ready && (op == pfe_pkg::OP_FINISH);

    `PFE_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(out_char), "letter changed in stall")
    `PFE_ASSERT_NOW(a_end_on_second, rsp_valid && message_end, pair_last, "end on a first letter")
    `PFE_ASSERT_NEXT(a_pair_second, rsp_take && !pair_last, rsp_valid && pair_last, "second missing")
    `PFE_ASSERT_NEXT(a_finish_busy, finish_take, !req_ready, "request taken during the fill")

endmodule

bind playfair_digraph_encryptor pfe_checker u_pfe_checker (.*);
